[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros: assertion shorthands for the octree level builder
// concurrent checks sampled on the rising clock, disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OBL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("octree level builder check failed");

// next-cycle implication
`define OBL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("octree level builder check failed");

`endif

[rtl/core/obl_pkg.sv]
// ----------------------------------------------------------------------------
// obl_pkg
// shared types and constants of the octree level builder
// ----------------------------------------------------------------------------
`default_nettype none

package obl_pkg;

    localparam int SLOT_BITS   = 3;
    localparam int CHILD_SLOTS = 8;
    localparam int CODE_W      = 30;
    localparam int NODE_W      = 27;
    localparam int ADDR_W      = 32;
    localparam int CNT_W       = 4;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_FIELD_W = 108;
    localparam int OUT_DATA_W  = 112;

    localparam logic [CHILD_SLOTS-1:0] FULL_MASK = 8'hFF;

    localparam logic KIND_PARENT = 1'b0;
    localparam logic KIND_WORD   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ABSORB,
        ST_CLOSE_HDR,
        ST_CLOSE_WORD
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic absorb;
        logic emit_hdr;
        logic emit_word;
        logic set_last;
    } dp_cmd_t;

    typedef struct packed {
        logic group_change;
        logic item_last;
        logic hdr_final;
        logic word_final;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/obl_ctrl.sv]
// ----------------------------------------------------------------------------
// obl_ctrl
// sequencer: takes one item, closes the open group on a parent change,
// merges the child, closes again at the end of the pass
// ----------------------------------------------------------------------------
`default_nettype none

module obl_ctrl
    import obl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;
    logic        end_phase_reg, end_phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            end_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            end_phase_reg <= end_phase_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        end_phase_next = end_phase_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE, ST_ABSORB:
            begin
                if (state_reg == ST_DECIDE && status.group_change)
                begin
                    end_phase_next = 1'b0;
                    state_next     = ST_CLOSE_HDR;
                end
                else
                begin
                    cmd.absorb = 1'b1;
                    if (status.item_last)
                    begin
                        end_phase_next = 1'b1;
                        state_next     = ST_CLOSE_HDR;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CLOSE_HDR:
            begin
                if (status.out_free)
                begin
                    cmd.emit_hdr = 1'b1;
                    cmd.set_last = status.hdr_final && (end_phase_reg || !status.item_last);
                    if (status.hdr_final)
                        state_next = end_phase_reg ? ST_IDLE : ST_ABSORB;
                    else
                        state_next = ST_CLOSE_WORD;
                end
            end
            ST_CLOSE_WORD:
            begin
                if (status.out_free)
                begin
                    cmd.emit_word = 1'b1;
                    cmd.set_last  = status.word_final && (end_phase_reg || !status.item_last);
                    if (status.word_final)
                        state_next = end_phase_reg ? ST_IDLE : ST_ABSORB;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/obl_dp.sv]
// ----------------------------------------------------------------------------
// obl_dp
// group registers, inner offset store, allocator and output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module obl_dp
    import obl_pkg::*;
#(
    parameter int MAX_LEVELS = 10
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic                     cfg_wdata,
    input  wire logic [CODE_W-1:0]        in_code,
    input  wire logic                     in_leaf,
    input  wire logic [ADDR_W-1:0]        in_offset,
    input  wire logic                     in_last,
    input  wire dp_cmd_t                  cmd,
    output dp_status_t                    status,
    input  wire logic                     m_tready,
    output logic                          m_tvalid,
    output logic                          m_tlast,
    output logic                          m_kind,
    output logic [OUT_FIELD_W-1:0]        m_fields
);

    localparam int CODE_BITS   = SLOT_BITS * MAX_LEVELS;
    localparam int PARENT_BITS = CODE_BITS - SLOT_BITS;

    logic                   top_level_reg;
    logic [PARENT_BITS-1:0] in_parent_reg;
    logic [SLOT_BITS-1:0]   in_slot_reg;
    logic                   in_leaf_reg;
    logic [ADDR_W-1:0]      in_offset_reg;
    logic                   in_last_reg;

    logic                   group_open_reg, group_open_next;
    logic [PARENT_BITS-1:0] group_code_reg, group_code_next;
    logic [CHILD_SLOTS-1:0] group_valid_reg, group_valid_next;
    logic [CHILD_SLOTS-1:0] group_leaf_reg, group_leaf_next;
    logic [CNT_W-1:0]       inner_count_reg, inner_count_next;
    logic [SLOT_BITS-1:0]   word_idx_reg, word_idx_next;
    logic [ADDR_W-1:0]      next_free_reg, next_free_next;
    logic [ADDR_W-1:0]      inner_offsets_reg [CHILD_SLOTS];

    logic                   out_valid_reg, out_valid_next;
    logic                   out_last_reg;
    logic                   out_kind_reg;
    logic [OUT_FIELD_W-1:0] out_data_reg;

    logic [CHILD_SLOTS-1:0] slot_bit;
    logic                   collapse;
    logic                   hdr_final;
    logic                   word_final;
    logic                   out_free;
    logic                   closing;
    logic                   store_offset;
    logic [NODE_W-1:0]      node_code;
    logic [ADDR_W-1:0]      cur_word;

    assign slot_bit   = CHILD_SLOTS'(1) << in_slot_reg;
    assign collapse   = ((group_valid_reg & group_leaf_reg) == FULL_MASK) && !top_level_reg;
    assign hdr_final  = collapse || (inner_count_reg == '0);
    assign word_final = (CNT_W'(word_idx_reg) + CNT_W'(1)) == inner_count_reg;
    assign out_free   = !out_valid_reg || m_tready;
    assign closing    = (cmd.emit_hdr && hdr_final) || (cmd.emit_word && word_final);
    assign node_code  = NODE_W'(group_code_reg);
    assign cur_word   = inner_offsets_reg[word_idx_reg];

    assign store_offset = cmd.absorb && ((group_valid_reg & slot_bit) == '0)
                          && !in_leaf_reg && (inner_count_reg < CNT_W'(CHILD_SLOTS));

    assign status.group_change = group_open_reg && (in_parent_reg != group_code_reg);
    assign status.item_last    = in_last_reg;
    assign status.hdr_final    = hdr_final;
    assign status.word_final   = word_final;
    assign status.out_free     = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_kind   = out_kind_reg;
    assign m_fields = out_data_reg;

    always_comb
    begin
        group_open_next  = group_open_reg;
        group_code_next  = group_code_reg;
        group_valid_next = group_valid_reg;
        group_leaf_next  = group_leaf_reg;
        inner_count_next = inner_count_reg;
        word_idx_next    = word_idx_reg;
        next_free_next   = next_free_reg;

        if (cmd.absorb)
        begin
            if (!group_open_reg)
            begin
                group_open_next = 1'b1;
                group_code_next = in_parent_reg;
            end
            // a repeated slot is dropped
            if ((group_valid_reg & slot_bit) == '0)
            begin
                group_valid_next = group_valid_reg | slot_bit;
                if (in_leaf_reg)
                    group_leaf_next = group_leaf_reg | slot_bit;
                else if (store_offset)
                    inner_count_next = inner_count_reg + CNT_W'(1);
            end
        end

        if (cmd.emit_hdr && !collapse)
            next_free_next = next_free_reg + ADDR_W'(1);

        if (cmd.emit_word)
        begin
            next_free_next = next_free_reg + ADDR_W'(1);
            word_idx_next  = word_idx_reg + SLOT_BITS'(1);
        end

        if (closing)
        begin
            group_open_next  = 1'b0;
            group_valid_next = '0;
            group_leaf_next  = '0;
            inner_count_next = '0;
            word_idx_next    = '0;
        end

        if (cmd.emit_hdr || cmd.emit_word)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_level_reg   <= 1'b0;
            group_open_reg  <= 1'b0;
            group_code_reg  <= '0;
            group_valid_reg <= '0;
            group_leaf_reg  <= '0;
            inner_count_reg <= '0;
            word_idx_reg    <= '0;
            next_free_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                top_level_reg <= cfg_wdata;
            group_open_reg  <= group_open_next;
            group_code_reg  <= group_code_next;
            group_valid_reg <= group_valid_next;
            group_leaf_reg  <= group_leaf_next;
            inner_count_reg <= inner_count_next;
            word_idx_reg    <= word_idx_next;
            next_free_reg   <= next_free_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_parent_reg <= in_code[CODE_BITS-1:SLOT_BITS];
            in_slot_reg   <= in_code[SLOT_BITS-1:0];
            in_leaf_reg   <= in_leaf;
            in_offset_reg <= in_offset;
            in_last_reg   <= in_last;
        end
        if (store_offset)
            inner_offsets_reg[inner_count_reg[SLOT_BITS-1:0]] <= in_offset_reg;
        if (cmd.emit_hdr)
        begin
            out_kind_reg <= KIND_PARENT;
            out_last_reg <= cmd.set_last;
            // fields low to high: node_code, collapsed, address, valid, leaf, word
            out_data_reg <= {ADDR_W'(0), group_leaf_reg, group_valid_reg,
                             (collapse ? ADDR_W'(0) : next_free_reg), collapse, node_code};
        end
        else if (cmd.emit_word)
        begin
            out_kind_reg <= KIND_WORD;
            out_last_reg <= cmd.set_last;
            out_data_reg <= {cur_word, group_leaf_reg, group_valid_reg,
                             next_free_reg, 1'b0, node_code};
        end
    end

    `OBL_ASSERT_IMPL(a_leaf_within_valid, clk, rst_n, 1'b1,
                     (group_leaf_reg & ~group_valid_reg) == '0)
    `OBL_ASSERT_IMPL(a_inner_count_matches, clk, rst_n, 1'b1,
                     $countones(group_valid_reg & ~group_leaf_reg) == int'(inner_count_reg))
    `OBL_ASSERT_NEXT(a_close_clears_group, clk, rst_n, closing,
                     !group_open_reg && group_valid_reg == '0 && out_valid_reg)
    `OBL_ASSERT_IMPL(a_emit_needs_room, clk, rst_n, cmd.emit_hdr || cmd.emit_word, out_free)

endmodule

`default_nettype wire

[rtl/core/octree_level_builder_core.sv]
// ----------------------------------------------------------------------------
// octree_level_builder_core
// one bottom-up pass of a sparse voxel octree build over morton-sorted children
// ----------------------------------------------------------------------------
// a child that closes nothing is taken in ST_IDLE and merged in ST_DECIDE
// a closing group emits its header, then one word per inner child,
//   then ST_ABSORB merges the child when a parent change closed the group,
//   with stalls while the output register is held by m_tready
// input: s_tready is high only in idle; no item is taken before the last is done
// reset: asynchronous active-low, clears group state, allocator and top_level
`default_nettype none

module octree_level_builder_core
    import obl_pkg::*;
#(
    parameter int MAX_LEVELS = 10
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_wdata,   // top_level
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,     // child_code, child_offset
    input  wire logic                  s_tuser,     // child_is_leaf
    input  wire logic                  s_tlast,     // last_of_level
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,     // node_code, collapsed, address,
                                                    // valid_bits, leaf_bits, child_word
    output logic                       m_tuser,     // kind
    output logic                       m_tlast      // last
);

    dp_cmd_t                cmd;
    dp_status_t             status;
    logic [OUT_FIELD_W-1:0] out_fields;

    obl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    obl_dp #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_code   (s_tdata[CODE_W-1:0]),
        .in_leaf   (s_tuser),
        .in_offset (s_tdata[CODE_W+ADDR_W-1:CODE_W]),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tlast   (m_tlast),
        .m_kind    (m_tuser),
        .m_fields  (out_fields)
    );

    assign m_tdata = OUT_DATA_W'(out_fields);

endmodule

`default_nettype wire
